// ===== design/pcc_pkg.sv =====
`timescale 1ns / 1ps
// pcc_pkg: widths, constants, register indexes and datapath commands
// for the clamped pid controller; used by all design files, depends on nothing

package pcc_pkg;

  // field and internal widths
  localparam int unsigned DATA_W     = 16;
  localparam int unsigned ERR_W      = 17;
  localparam int unsigned DELTA_W    = 18;
  localparam int unsigned ACC_W      = 48;
  localparam int unsigned LIM_W      = 40;
  localparam int unsigned CLAMP_W    = 41;
  localparam int unsigned MUL_A_W    = 42;
  localparam int unsigned MUL_B_W    = 18;
  localparam int unsigned PROD_W     = 60;
  localparam int unsigned DIV_N_W    = 56;
  localparam int unsigned DIV_D_W    = 16;
  localparam int unsigned DIV_STEPS  = DIV_N_W / 2;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS + 1);
  localparam int unsigned TERM_W     = 48;
  localparam int unsigned SUM_W      = 50;
  localparam int unsigned VAL_W      = 42;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 40;

  // scale of milliseconds to seconds
  localparam int unsigned MS_SCALE = 1000;

  // accumulator saturation limits
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // register reset values
  localparam logic signed [DATA_W-1:0] GAIN_P_RST  = 16'sd256;
  localparam logic signed [DATA_W-1:0] GAIN_I_RST  = 16'sd0;
  localparam logic signed [DATA_W-1:0] GAIN_D_RST  = 16'sd0;
  localparam logic signed [DATA_W-1:0] OUT_MIN_RST = 16'sh8000;
  localparam logic signed [DATA_W-1:0] OUT_MAX_RST = 16'sh7fff;
  localparam logic [LIM_W-1:0]         LIMIT_RST   = 40'd1000000;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P  = 3'd0,
    REG_GAIN_I  = 3'd1,
    REG_GAIN_D  = 3'd2,
    REG_OUT_MIN = 3'd3,
    REG_OUT_MAX = 3'd4,
    REG_LIMIT   = 3'd5
  } reg_idx_e;

  // commands from controller to datapath
  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_MUL_EL,
    CMD_ACC,
    CMD_CLAMP,
    CMD_MUL_P,
    CMD_SAVE_P,
    CMD_MUL_I,
    CMD_DIV_I,
    CMD_SAVE_I,
    CMD_MUL_GD,
    CMD_MUL_K,
    CMD_DIV_D,
    CMD_SAVE_D,
    CMD_SUM,
    CMD_SCALE,
    CMD_LIMIT
  } cmd_e;

  // status from datapath to controller
  typedef struct packed {
    logic div_done;
    logic div_busy;
  } status_t;

endpackage

// ===== design/pcc_div.sv =====
`timescale 1ns / 1ps
// pcc_div: unsigned restoring divider, two quotient bits per cycle
// depends on pcc_pkg for widths

module pcc_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [pcc_pkg::DIV_N_W-1:0]     dividend_i,
  input  logic [pcc_pkg::DIV_D_W-1:0]     divisor_i,
  output logic                            busy_o,
  output logic                            done_o,
  output logic [pcc_pkg::DIV_N_W-1:0]     quotient_o
);

  logic                              busy_q, busy_d;
  logic                              done_q, done_d;
  logic [pcc_pkg::DIV_CNT_W-1:0]     cnt_q, cnt_d;
  logic [pcc_pkg::DIV_N_W-1:0]       quo_q, quo_d;
  logic [pcc_pkg::DIV_D_W-1:0]       rem_q, rem_d;
  logic [pcc_pkg::DIV_D_W-1:0]       den_q, den_d;

  logic [pcc_pkg::DIV_D_W:0]         try0, try1;
  logic [pcc_pkg::DIV_D_W-1:0]       rem_mid;
  logic                              bit0, bit1;

  // two dependent restoring steps
  always_comb begin
    try0    = {rem_q, quo_q[pcc_pkg::DIV_N_W-1]};
    bit0    = (try0 >= {1'b0, den_q});
    rem_mid = bit0 ? pcc_pkg::DIV_D_W'(try0 - {1'b0, den_q})
                   : try0[pcc_pkg::DIV_D_W-1:0];
    try1    = {rem_mid, quo_q[pcc_pkg::DIV_N_W-2]};
    bit1    = (try1 >= {1'b0, den_q});
  end

  // next state of the iteration
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = pcc_pkg::DIV_CNT_W'(pcc_pkg::DIV_STEPS);
      quo_d  = dividend_i;
      rem_d  = '0;
      den_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[pcc_pkg::DIV_N_W-3:0], bit0, bit1};
      rem_d = bit1 ? pcc_pkg::DIV_D_W'(try1 - {1'b0, den_q})
                   : try1[pcc_pkg::DIV_D_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == pcc_pkg::DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // data registers
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

  // a new division never starts over a running one
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

  // done follows a busy cycle
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider done without running");

  // start leads into the busy phase
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q)
    else $error("divider did not start");

endmodule

// ===== design/pcc_dpath.sv =====
`timescale 1ns / 1ps
// pcc_dpath: config registers, controller state, shared multiplier and divider
// depends on pcc_pkg and pcc_div

module pcc_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pcc_pkg::cmd_e                       cmd_i,
  output pcc_pkg::status_t                    status_o,
  input  logic                                cfg_we_i,
  input  logic [pcc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [pcc_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic signed [pcc_pkg::DATA_W-1:0]   measured_i,
  input  logic signed [pcc_pkg::DATA_W-1:0]   setpoint_i,
  input  logic [pcc_pkg::DATA_W-1:0]          elapsed_ms_i,
  output logic signed [pcc_pkg::DATA_W-1:0]   drive_o,
  output logic                                output_clamped_o
);

  // configuration
  logic signed [pcc_pkg::DATA_W-1:0] gain_p_q, gain_i_q, gain_d_q;
  logic signed [pcc_pkg::DATA_W-1:0] out_min_q, out_max_q;
  logic [pcc_pkg::LIM_W-1:0]         limit_q;

  // controller state
  logic signed [pcc_pkg::ACC_W-1:0]  error_sum_q;
  logic signed [pcc_pkg::ERR_W-1:0]  last_err_q;
  logic                              first_q;

  // working registers
  logic signed [pcc_pkg::ERR_W-1:0]   err_q;
  logic signed [pcc_pkg::DELTA_W-1:0] delta_q;
  logic [pcc_pkg::DATA_W-1:0]         el_q;
  logic                               dzero_q;
  logic signed [pcc_pkg::CLAMP_W-1:0] clamped_q;
  logic signed [pcc_pkg::PROD_W-1:0]  prod_q;
  logic                               neg_q;
  logic signed [pcc_pkg::TERM_W-1:0]  term_p_q, term_i_q, term_d_q;
  logic signed [pcc_pkg::SUM_W-1:0]   sum_q;
  logic signed [pcc_pkg::VAL_W-1:0]   val_q;
  logic signed [pcc_pkg::DATA_W-1:0]  drive_q;
  logic                               flag_q;

  logic signed [pcc_pkg::ERR_W-1:0]   err_new;
  logic signed [pcc_pkg::MUL_A_W-1:0] mul_a;
  logic signed [pcc_pkg::MUL_B_W-1:0] mul_b;
  logic signed [pcc_pkg::PROD_W-1:0]  mul_p;
  logic                               mul_en;
  logic signed [pcc_pkg::ACC_W:0]     acc_sum;
  logic signed [pcc_pkg::ACC_W-1:0]   acc_sat;
  logic signed [pcc_pkg::ACC_W:0]     es_ext, lim_pos, lim_neg;
  logic [pcc_pkg::PROD_W-1:0]         prod_mag;
  logic                               div_start;
  logic [pcc_pkg::DIV_D_W-1:0]        div_den;
  logic [pcc_pkg::DIV_N_W-1:0]        div_quot;
  logic                               div_busy, div_done;
  logic signed [pcc_pkg::TERM_W-1:0]  quot_t, quot_s;
  logic signed [pcc_pkg::SUM_W-1:0]   sum_bias;
  logic signed [pcc_pkg::SUM_W-1:0]   sum_shift;
  logic signed [pcc_pkg::VAL_W-1:0]   omin, omax;

  assign err_new = pcc_pkg::ERR_W'(setpoint_i) - pcc_pkg::ERR_W'(measured_i);

  // multiplier operand select
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (cmd_i)
      pcc_pkg::CMD_MUL_EL: begin
        mul_a = pcc_pkg::MUL_A_W'(err_q);
        mul_b = $signed({2'b00, el_q});
      end
      pcc_pkg::CMD_MUL_P: begin
        mul_a = pcc_pkg::MUL_A_W'(err_q);
        mul_b = pcc_pkg::MUL_B_W'(gain_p_q);
      end
      pcc_pkg::CMD_MUL_I: begin
        mul_a = pcc_pkg::MUL_A_W'(clamped_q);
        mul_b = pcc_pkg::MUL_B_W'(gain_i_q);
      end
      pcc_pkg::CMD_MUL_GD: begin
        mul_a = pcc_pkg::MUL_A_W'(delta_q);
        mul_b = pcc_pkg::MUL_B_W'(gain_d_q);
      end
      pcc_pkg::CMD_MUL_K: begin
        mul_a = pcc_pkg::MUL_A_W'($signed(prod_q[pcc_pkg::DELTA_W+pcc_pkg::DATA_W-1:0]));
        mul_b = pcc_pkg::MUL_B_W'(pcc_pkg::MS_SCALE);
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  assign mul_p = pcc_pkg::PROD_W'(mul_a) * pcc_pkg::PROD_W'(mul_b);

  // saturating accumulate
  always_comb begin
    acc_sum = pcc_pkg::ACC_W'(1)'(0) + (pcc_pkg::ACC_W+1)'(error_sum_q)
            + (pcc_pkg::ACC_W+1)'($signed(prod_q[pcc_pkg::ERR_W+pcc_pkg::DATA_W-1:0]));
    if (acc_sum[pcc_pkg::ACC_W] != acc_sum[pcc_pkg::ACC_W-1]) begin
      acc_sat = acc_sum[pcc_pkg::ACC_W] ? pcc_pkg::ACC_MIN : pcc_pkg::ACC_MAX;
    end else begin
      acc_sat = acc_sum[pcc_pkg::ACC_W-1:0];
    end
  end

  // integral limit compare
  always_comb begin
    es_ext  = (pcc_pkg::ACC_W+1)'(error_sum_q);
    lim_pos = $signed({{(pcc_pkg::ACC_W+1-pcc_pkg::LIM_W){1'b0}}, limit_q});
    lim_neg = -lim_pos;
  end

  // divider operands and signed quotient
  assign prod_mag = prod_q[pcc_pkg::PROD_W-1] ? pcc_pkg::PROD_W'(-prod_q)
                                              : pcc_pkg::PROD_W'(prod_q);
  assign div_start = (cmd_i == pcc_pkg::CMD_DIV_I) || (cmd_i == pcc_pkg::CMD_DIV_D);
  assign div_den   = (cmd_i == pcc_pkg::CMD_DIV_D) ? el_q
                                                   : pcc_pkg::DIV_D_W'(pcc_pkg::MS_SCALE);
  assign quot_t    = $signed(div_quot[pcc_pkg::TERM_W-1:0]);
  assign quot_s    = neg_q ? -quot_t : quot_t;

  pcc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_mag[pcc_pkg::DIV_N_W-1:0]),
    .divisor_i  (div_den),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // divide by 256 toward zero
  always_comb begin
    sum_bias  = sum_q + (sum_q[pcc_pkg::SUM_W-1] ? pcc_pkg::SUM_W'(255) : '0);
    sum_shift = sum_bias >>> 8;
    omin      = pcc_pkg::VAL_W'(out_min_q);
    omax      = pcc_pkg::VAL_W'(out_max_q);
  end

  // configuration and controller state, reset to defined values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q    <= pcc_pkg::GAIN_P_RST;
      gain_i_q    <= pcc_pkg::GAIN_I_RST;
      gain_d_q    <= pcc_pkg::GAIN_D_RST;
      out_min_q   <= pcc_pkg::OUT_MIN_RST;
      out_max_q   <= pcc_pkg::OUT_MAX_RST;
      limit_q     <= pcc_pkg::LIMIT_RST;
      error_sum_q <= '0;
      last_err_q  <= '0;
      first_q     <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        case (pcc_pkg::reg_idx_e'(cfg_index_i))
          pcc_pkg::REG_GAIN_P:  gain_p_q  <= $signed(cfg_data_i[pcc_pkg::DATA_W-1:0]);
          pcc_pkg::REG_GAIN_I:  gain_i_q  <= $signed(cfg_data_i[pcc_pkg::DATA_W-1:0]);
          pcc_pkg::REG_GAIN_D:  gain_d_q  <= $signed(cfg_data_i[pcc_pkg::DATA_W-1:0]);
          pcc_pkg::REG_OUT_MIN: out_min_q <= $signed(cfg_data_i[pcc_pkg::DATA_W-1:0]);
          pcc_pkg::REG_OUT_MAX: out_max_q <= $signed(cfg_data_i[pcc_pkg::DATA_W-1:0]);
          pcc_pkg::REG_LIMIT:   limit_q   <= cfg_data_i[pcc_pkg::LIM_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd_i == pcc_pkg::CMD_LOAD) begin
        last_err_q <= err_new;
        first_q    <= 1'b0;
      end
      if (cmd_i == pcc_pkg::CMD_ACC) begin
        error_sum_q <= acc_sat;
      end
    end
  end

  // working registers, no reset
  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_q <= mul_p;
    end
    case (cmd_i)
      pcc_pkg::CMD_LOAD: begin
        err_q   <= err_new;
        delta_q <= pcc_pkg::DELTA_W'(err_new) - pcc_pkg::DELTA_W'(last_err_q);
        el_q    <= elapsed_ms_i;
        dzero_q <= first_q || (elapsed_ms_i == '0);
      end
      pcc_pkg::CMD_CLAMP: begin
        if (es_ext > lim_pos) begin
          clamped_q <= pcc_pkg::CLAMP_W'(lim_pos);
        end else if (es_ext < lim_neg) begin
          clamped_q <= pcc_pkg::CLAMP_W'(lim_neg);
        end else begin
          clamped_q <= pcc_pkg::CLAMP_W'(es_ext);
        end
      end
      pcc_pkg::CMD_SAVE_P: begin
        term_p_q <= pcc_pkg::TERM_W'($signed(prod_q[pcc_pkg::ERR_W+pcc_pkg::DATA_W-1:0]));
      end
      pcc_pkg::CMD_DIV_I, pcc_pkg::CMD_DIV_D: begin
        neg_q <= prod_q[pcc_pkg::PROD_W-1];
      end
      pcc_pkg::CMD_SAVE_I: begin
        term_i_q <= quot_s;
      end
      pcc_pkg::CMD_SAVE_D: begin
        term_d_q <= dzero_q ? '0 : quot_s;
      end
      pcc_pkg::CMD_SUM: begin
        sum_q <= pcc_pkg::SUM_W'(term_p_q) + pcc_pkg::SUM_W'(term_i_q)
               + pcc_pkg::SUM_W'(term_d_q);
      end
      pcc_pkg::CMD_SCALE: begin
        val_q <= sum_shift[pcc_pkg::VAL_W-1:0];
      end
      pcc_pkg::CMD_LIMIT: begin
        if (val_q > omax) begin
          drive_q <= out_max_q;
          flag_q  <= 1'b1;
        end else if (val_q < omin) begin
          drive_q <= out_min_q;
          flag_q  <= 1'b1;
        end else begin
          drive_q <= val_q[pcc_pkg::DATA_W-1:0];
          flag_q  <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  assign status_o.div_done = div_done;
  assign status_o.div_busy = div_busy;
  assign drive_o           = drive_q;
  assign output_clamped_o  = flag_q;

endmodule

// ===== design/pcc_ctrl.sv =====
`timescale 1ns / 1ps
// pcc_ctrl: sequencer for one update, input and output handshakes
// depends on pcc_pkg for commands and status

module pcc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  pcc_pkg::status_t  status_i,
  output pcc_pkg::cmd_e     cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_MUL_EL,
    S_ACC,
    S_CLAMP,
    S_MUL_P,
    S_SAVE_P,
    S_MUL_I,
    S_DIV_I,
    S_WAIT_I,
    S_SAVE_I,
    S_MUL_GD,
    S_MUL_K,
    S_DIV_D,
    S_WAIT_D,
    S_SAVE_D,
    S_SUM,
    S_SCALE,
    S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   wr_out;
  logic   slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;

  // command decode and next state
  always_comb begin
    state_d = state_q;
    cmd_o   = pcc_pkg::CMD_NONE;
    wr_out  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = pcc_pkg::CMD_LOAD;
          state_d = S_MUL_EL;
        end
      end
      S_MUL_EL: begin
        cmd_o   = pcc_pkg::CMD_MUL_EL;
        state_d = S_ACC;
      end
      S_ACC: begin
        cmd_o   = pcc_pkg::CMD_ACC;
        state_d = S_CLAMP;
      end
      S_CLAMP: begin
        cmd_o   = pcc_pkg::CMD_CLAMP;
        state_d = S_MUL_P;
      end
      S_MUL_P: begin
        cmd_o   = pcc_pkg::CMD_MUL_P;
        state_d = S_SAVE_P;
      end
      S_SAVE_P: begin
        cmd_o   = pcc_pkg::CMD_SAVE_P;
        state_d = S_MUL_I;
      end
      S_MUL_I: begin
        cmd_o   = pcc_pkg::CMD_MUL_I;
        state_d = S_DIV_I;
      end
      S_DIV_I: begin
        cmd_o   = pcc_pkg::CMD_DIV_I;
        state_d = S_WAIT_I;
      end
      S_WAIT_I: begin
        if (status_i.div_done) begin
          state_d = S_SAVE_I;
        end
      end
      S_SAVE_I: begin
        cmd_o   = pcc_pkg::CMD_SAVE_I;
        state_d = S_MUL_GD;
      end
      S_MUL_GD: begin
        cmd_o   = pcc_pkg::CMD_MUL_GD;
        state_d = S_MUL_K;
      end
      S_MUL_K: begin
        cmd_o   = pcc_pkg::CMD_MUL_K;
        state_d = S_DIV_D;
      end
      S_DIV_D: begin
        cmd_o   = pcc_pkg::CMD_DIV_D;
        state_d = S_WAIT_D;
      end
      S_WAIT_D: begin
        if (status_i.div_done) begin
          state_d = S_SAVE_D;
        end
      end
      S_SAVE_D: begin
        cmd_o   = pcc_pkg::CMD_SAVE_D;
        state_d = S_SUM;
      end
      S_SUM: begin
        cmd_o   = pcc_pkg::CMD_SUM;
        state_d = S_SCALE;
      end
      S_SCALE: begin
        cmd_o   = pcc_pkg::CMD_SCALE;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (slot_free) begin
          cmd_o   = pcc_pkg::CMD_LIMIT;
          wr_out  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output word held until taken
  assign out_valid_d = (out_valid_q && out_stall_i) || wr_out;

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  // a result word never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_out |-> (!out_valid_q || !out_stall_i))
    else $error("result word overwritten");

  // after an accepted word the input side is busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted twice in a row");

  // a result word appears only after the output state
  a_valid_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("output valid without a result");

endmodule

// ===== design/pid_controller_clamped.sv =====
`timescale 1ns / 1ps
// pid_controller_clamped: top level, joins controller and datapath
// depends on pcc_pkg, pcc_ctrl, pcc_dpath (and pcc_div below it)

// One update runs from acceptance to a result word through the sequencer's
// steps, which all share one multiplier, and through two divisions in the
// shared radix-4 divider (the integral term by 1000 and the derivative
// term by elapsed_ms), each awaited by the sequencer. A new word is
// accepted only while the sequencer is idle; the finished result sits in an
// output register, so the next word can be taken while it waits to be read.
// Configuration writes are accepted in every cycle and must be issued only
// while no update is in progress.

module pid_controller_clamped (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [pcc_pkg::DATA_W-1:0]   measured_i,
  input  logic signed [pcc_pkg::DATA_W-1:0]   setpoint_i,
  input  logic [pcc_pkg::DATA_W-1:0]          elapsed_ms_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [pcc_pkg::DATA_W-1:0]   drive_o,
  output logic                                output_clamped_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pcc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [pcc_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  pcc_pkg::cmd_e    cmd;
  pcc_pkg::status_t status;
  logic             cfg_we;

  // config port always ready
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  pcc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pcc_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .measured_i       (measured_i),
    .setpoint_i       (setpoint_i),
    .elapsed_ms_i     (elapsed_ms_i),
    .drive_o          (drive_o),
    .output_clamped_o (output_clamped_o)
  );

endmodule
